// ===== hdl/ilr_pkg.sv =====
// shared types and character codes for the integer literal recognizer
// no dependencies; used by every module under hdl except ilr_out_stage
package ilr_pkg;

  localparam logic [7:0] ChDigit0 = 8'd48;
  localparam logic [7:0] ChDigit1 = 8'd49;
  localparam logic [7:0] ChDigit7 = 8'd55;
  localparam logic [7:0] ChDigit9 = 8'd57;
  localparam logic [7:0] ChUpperA = 8'd65;
  localparam logic [7:0] ChUpperF = 8'd70;
  localparam logic [7:0] ChLowerA = 8'd97;
  localparam logic [7:0] ChLowerF = 8'd102;
  localparam logic [7:0] ChMinus  = 8'd45;
  localparam logic [7:0] ChLowerU = 8'd117;
  localparam logic [7:0] ChUpperU = 8'd85;
  localparam logic [7:0] ChLowerL = 8'd108;
  localparam logic [7:0] ChUpperL = 8'd76;
  localparam logic [7:0] ChLowerX = 8'd120;
  localparam logic [7:0] ChUpperX = 8'd88;

  typedef enum logic [9:0] {
    PhStart  = 10'b00_0000_0001,
    PhMinus  = 10'b00_0000_0010,
    PhZero   = 10'b00_0000_0100,
    PhDec    = 10'b00_0000_1000,
    PhOct    = 10'b00_0001_0000,
    PhHexPre = 10'b00_0010_0000,
    PhHex    = 10'b00_0100_0000,
    PhSufU   = 10'b00_1000_0000,
    PhSufUl  = 10'b01_0000_0000,
    PhDead   = 10'b10_0000_0000
  } phase_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_mark;
  } beat_t;

endpackage

// ===== hdl/integer_literal_recognizer_unit.sv =====
// top level of the integer literal recognizer: input register, phase automaton,
// result register; depends on ilr_pkg, ilr_in_stage, ilr_phase, ilr_out_stage
// flow: a character beat is held in the input register, then steps the phase; an end
// beat waits in the input register while the result register is full, then loads it
// throughput: one beat per cycle while no end beat waits on a full result register
// reset: phase returns to start of string, both stages empty
module integer_literal_recognizer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_code
  input  logic       s_axis_tlast,   // end_mark
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] accepted, [7:1] zero
);
  import ilr_pkg::*;

  beat_t in_beat, stage_beat;
  logic  stage_valid, advance, out_full, accept, accepted;

  assign in_beat.char_code = s_axis_tdata;
  assign in_beat.end_mark  = s_axis_tlast;

  assign advance = stage_valid && (!stage_beat.end_mark || !out_full);

  ilr_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .beat_i    (in_beat),
    .valid_o   (stage_valid),
    .advance_i (advance),
    .beat_o    (stage_beat)
  );

  ilr_phase u_phase (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance && !stage_beat.end_mark),
    .restart_i   (advance && stage_beat.end_mark),
    .char_code_i (stage_beat.char_code),
    .accept_o    (accept)
  );

  ilr_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && stage_beat.end_mark),
    .accepted_i (accept),
    .full_o     (out_full),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .accepted_o (accepted)
  );

  assign m_axis_tdata = {7'd0, accepted};
endmodule

// ===== hdl/ilr_in_stage.sv =====
// input register stage of the integer literal recognizer
// depends on ilr_pkg
module ilr_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  ilr_pkg::beat_t beat_i,
  output logic          valid_o,
  input  logic          advance_i,
  output ilr_pkg::beat_t beat_o
);
  import ilr_pkg::*;

  logic  valid_q, valid_d;
  beat_t beat_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      beat_q <= beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;
endmodule

// ===== hdl/ilr_phase.sv =====
// scan phase automaton of the integer literal recognizer
// depends on ilr_pkg
module ilr_phase (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       restart_i,
  input  logic [7:0] char_code_i,
  output logic       accept_o
);
  import ilr_pkg::*;

  phase_e phase_q, phase_d, next_ph;
  logic   is_dec, is_oct, is_hex, is_u, is_l, is_x;

  assign is_dec = (char_code_i >= ChDigit0) && (char_code_i <= ChDigit9);
  assign is_oct = (char_code_i >= ChDigit0) && (char_code_i <= ChDigit7);
  assign is_hex = is_dec || ((char_code_i >= ChUpperA) && (char_code_i <= ChUpperF))
                  || ((char_code_i >= ChLowerA) && (char_code_i <= ChLowerF));
  assign is_u   = (char_code_i == ChLowerU) || (char_code_i == ChUpperU);
  assign is_l   = (char_code_i == ChLowerL) || (char_code_i == ChUpperL);
  assign is_x   = (char_code_i == ChLowerX) || (char_code_i == ChUpperX);

  always_comb begin
    next_ph = PhDead;
    case (phase_q)
      PhStart, PhMinus: begin
        if ((phase_q == PhStart) && (char_code_i == ChMinus)) next_ph = PhMinus;
        else if (char_code_i == ChDigit0) next_ph = PhZero;
        else if ((char_code_i >= ChDigit1) && (char_code_i <= ChDigit9)) next_ph = PhDec;
      end
      PhZero: begin
        if (is_x) next_ph = PhHexPre;
        else if (is_oct) next_ph = PhOct;
        else if (is_u) next_ph = PhSufU;
      end
      PhOct: begin
        if (is_oct) next_ph = PhOct;
        else if (is_u) next_ph = PhSufU;
      end
      PhDec: begin
        if (is_dec) next_ph = PhDec;
        else if (is_u) next_ph = PhSufU;
      end
      PhHexPre: begin
        if (is_hex) next_ph = PhHex;
      end
      PhHex: begin
        if (is_hex) next_ph = PhHex;
        else if (is_u) next_ph = PhSufU;
      end
      PhSufU: begin
        if (is_l) next_ph = PhSufUl;
      end
      default: next_ph = PhDead;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    if (restart_i) phase_d = PhStart;
    else if (step_i) phase_d = next_ph;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
    end else begin
      phase_q <= phase_d;
    end
  end

  assign accept_o = (phase_q == PhZero) || (phase_q == PhDec) || (phase_q == PhOct)
                    || (phase_q == PhHex) || (phase_q == PhSufU) || (phase_q == PhSufUl);
endmodule

// ===== hdl/ilr_out_stage.sv =====
// result register of the integer literal recognizer
// no package dependencies
module ilr_out_stage (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  logic accepted_i,
  output logic full_o,
  output logic valid_o,
  input  logic ready_i,
  output logic accepted_o
);
  logic valid_q, valid_d;
  logic accepted_q;

  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      accepted_q <= accepted_i;
    end
  end

  assign full_o     = valid_q && !ready_i;
  assign valid_o    = valid_q;
  assign accepted_o = accepted_q;
endmodule

// ===== test/ilr_checker.sv =====
// scoreboard for the integer literal recognizer: follows the literal phase from the
// accepted input beats and checks every verdict beat in order; depends on ilr_pkg
module ilr_checker
  import ilr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  input  logic       s_tready_i,
  input  logic [7:0] s_tdata_i,
  input  logic       s_tlast_i,
  input  logic       m_tvalid_i,
  input  logic       m_tready_i,
  input  logic [7:0] m_tdata_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o,
  output int         accepts_o
);
  timeunit 1ns;
  timeprecision 1ps;

  phase_e lit_phase;
  logic   verdict_q[$];
  int     errors;
  int     checked;
  int     accepts;

  function automatic phase_e advance_phase(phase_e ph, logic [7:0] c);
    logic dec;
    logic oct;
    logic hex;
    logic suf_u;
    dec   = (c >= ChDigit0) && (c <= ChDigit9);
    oct   = (c >= ChDigit0) && (c <= ChDigit7);
    hex   = dec || ((c >= ChUpperA) && (c <= ChUpperF)) ||
            ((c >= ChLowerA) && (c <= ChLowerF));
    suf_u = (c == ChLowerU) || (c == ChUpperU);
    case (ph)
      PhStart, PhMinus: begin
        if (ph == PhStart && c == ChMinus) return PhMinus;
        if (c == ChDigit0) return PhZero;
        if (dec) return PhDec;
        return PhDead;
      end
      PhZero: begin
        if (c == ChLowerX || c == ChUpperX) return PhHexPre;
        if (oct) return PhOct;
        if (suf_u) return PhSufU;
        return PhDead;
      end
      PhOct, PhDec, PhHex: begin
        if ((ph == PhOct && oct) || (ph == PhDec && dec) || (ph == PhHex && hex)) return ph;
        if (suf_u) return PhSufU;
        return PhDead;
      end
      PhHexPre: begin
        if (hex) return PhHex;
        return PhDead;
      end
      PhSufU: begin
        if (c == ChLowerL || c == ChUpperL) return PhSufUl;
        return PhDead;
      end
      default: begin
        return PhDead;
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic want;
    if (!rst_ni) begin
      lit_phase = PhStart;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (verdict_q.size() == 0) begin
          flag_mismatch($sformatf("verdict beat %0b with nothing outstanding", m_tdata_i[0]));
        end else begin
          want = verdict_q.pop_front();
          if (m_tdata_i[0] !== want)
            flag_mismatch($sformatf("accepted is %b, predicted %b", m_tdata_i[0], want));
          if (m_tdata_i[7:1] !== 7'd0)
            flag_mismatch($sformatf("tdata padding is %b, not zero", m_tdata_i[7:1]));
          checked++;
          if (want) accepts++;
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (s_tlast_i) begin
          verdict_q.push_back(lit_phase inside {PhZero, PhDec, PhOct, PhHex, PhSufU, PhSufUl});
          lit_phase = PhStart;
        end else begin
          lit_phase = advance_phase(lit_phase, s_tdata_i);
        end
      end
    end
    pending_o    <= verdict_q.size();
    fail_count_o <= errors;
    checked_o    <= checked;
    accepts_o    <= accepts;
  end

endmodule

// ===== test/tb_top.sv =====
// testbench top for integer_literal_recognizer_unit: drives directed and random
// candidate literals with random stalls on both streams; ilr_checker does the scoring
// depends on ilr_pkg, integer_literal_recognizer_unit and ilr_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ilr_pkg::*;

  localparam int NumItems   = 950;
  localparam int TailItems  = 150;
  localparam int CycleLimit = 400000;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic [7:0] s_axis_tdata  = 8'd0;
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tready = 1'b1;
  logic       s_axis_tready;
  logic       m_axis_tvalid;
  logic [7:0] m_axis_tdata;

  logic       tx_idle_en = 1'b0;
  logic       rx_idle_en = 1'b0;
  int         stall_left = 0;
  int         beats_sent = 0;
  int         strings_sent = 0;
  int         cycles = 0;
  int         fail_count;
  int         pending;
  int         checked;
  int         accepts;
  logic [7:0] lit_chars[$];

  integer_literal_recognizer_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  ilr_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tlast_i    (s_axis_tlast),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .accepts_o    (accepts)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycles, pending);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // receiver backpressure in bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
      stall_left    <= $urandom_range(1, 15);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_beat(input logic [7:0] c, input logic e);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= e;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic send_literal();
    foreach (lit_chars[i]) send_beat(lit_chars[i], 1'b0);
    send_beat(8'($urandom_range(0, 255)), 1'b1);
    strings_sent++;
  endtask

  task automatic send_text(input string s);
    lit_chars = {};
    for (int i = 0; i < s.len(); i++) lit_chars.push_back(s[i]);
    send_literal();
  endtask

  task automatic drain_verdicts();
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [7:0] hex_char();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'(ChDigit0 + r);
    if (r < 16) return 8'(ChUpperA + r - 10);
    return 8'(ChLowerA + r - 16);
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 7))
      0: return ChMinus;
      1: return 8'(ChDigit0 + $urandom_range(0, 9));
      2: return $urandom_range(0, 1) ? ChUpperU : ChLowerU;
      3: return $urandom_range(0, 1) ? ChUpperL : ChLowerL;
      4: return $urandom_range(0, 1) ? ChUpperX : ChLowerX;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // well-formed literals with random digits and suffix, half of them then damaged
  task automatic build_literal();
    lit_chars = {};
    if ($urandom_range(0, 3) == 0) lit_chars.push_back(ChMinus);
    case ($urandom_range(0, 2))
      0: begin
        lit_chars.push_back(8'(ChDigit1 + $urandom_range(0, 8)));
        repeat ($urandom_range(0, 6)) lit_chars.push_back(8'(ChDigit0 + $urandom_range(0, 9)));
      end
      1: begin
        lit_chars.push_back(ChDigit0);
        repeat ($urandom_range(0, 6)) lit_chars.push_back(8'(ChDigit0 + $urandom_range(0, 7)));
      end
      default: begin
        lit_chars.push_back(ChDigit0);
        lit_chars.push_back($urandom_range(0, 1) ? ChUpperX : ChLowerX);
        repeat ($urandom_range(1, 6)) lit_chars.push_back(hex_char());
      end
    endcase
    if ($urandom_range(0, 2) == 0) begin
      lit_chars.push_back($urandom_range(0, 1) ? ChUpperU : ChLowerU);
      if ($urandom_range(0, 1)) lit_chars.push_back($urandom_range(0, 1) ? ChUpperL : ChLowerL);
    end
    case ($urandom_range(0, 7))
      0: lit_chars[$urandom_range(0, lit_chars.size() - 1)] = noise_char();
      1: lit_chars.insert($urandom_range(0, lit_chars.size()), noise_char());
      2: repeat ($urandom_range(1, lit_chars.size())) void'(lit_chars.pop_back());
      3: begin
        lit_chars = {};
        repeat ($urandom_range(0, 5)) lit_chars.push_back(noise_char());
      end
      default: ;
    endcase
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("");
    send_text("-");
    send_text("0X");
    send_text("u");
    send_text("07UL");
    send_text("-9u");
    send_text("0xFu");
    send_text("08l");
    lit_chars = {8'hFF};
    send_literal();
    lit_chars = {8'h00};
    send_literal();

    s_axis_tvalid <= 1'b0;
    drain_verdicts();

    while (beats_sent < NumItems) begin
      if (beats_sent >= NumItems - TailItems) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end else begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
      end
      build_literal();
      send_literal();
      if ($urandom_range(0, 40) == 0) begin
        s_axis_tvalid <= 1'b0;
        drain_verdicts();
      end
    end

    s_axis_tvalid <= 1'b0;
    drain_verdicts();
    repeat (8) @(posedge clk_i);

    $display("%0d literals in %0d beats; %0d verdicts checked, %0d of them accepts",
             strings_sent, beats_sent, checked, accepts);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
